/* rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes and types of the positional list engine: command and status
// codes, fixed field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CMD_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int FPOS_W   = 7;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_POP_FRONT  = 4'd1,
    CMD_PUSH_BACK  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_INSERT_AT  = 4'd4,
    CMD_DELETE_AT  = 4'd5,
    CMD_REWRITE_AT = 4'd6,
    CMD_FIND       = 4'd7,
    CMD_CLEAR      = 4'd8
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

/* rtl/ple_cmd_if.sv */
// ----------------------------------------------------------------------------
// ple_cmd_if
// Command channel of the positional list engine: valid/ready and one word
// of command, value and position.
// ----------------------------------------------------------------------------
interface ple_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::CMD_W-1:0]           command;
  logic signed [ple_pkg::VALUE_W-1:0]  value;
  logic [ple_pkg::POS_W-1:0]           position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

/* rtl/ple_rsp_if.sv */
// ----------------------------------------------------------------------------
// ple_rsp_if
// Response channel of the positional list engine: valid/ready and one word
// of status, found position and count.
// ----------------------------------------------------------------------------
interface ple_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ple_pkg::STATUS_W-1:0]  status;
  logic [ple_pkg::FPOS_W-1:0]    found_position;
  logic [ple_pkg::COUNT_W-1:0]   count;

  modport source (output valid, status, found_position, count, input ready);
  modport sink   (input valid, status, found_position, count, output ready);
endinterface

/* rtl/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, loads new data or a neighbor's entry and
// compares its entry against the search key.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  ple_pkg::cell_ctl_t    ctl_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    priority if (ctl_i.take_new) begin
      data_d = value_i;
    end else if (ctl_i.take_left) begin
      data_d = left_i;
    end else if (ctl_i.take_right) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = (data_q == value_i);

endmodule

/* rtl/ple_search.sv */
// ----------------------------------------------------------------------------
// ple_search
// Registered binary tree that finds the lowest set bit of the match vector,
// one tree level per cycle.
// ----------------------------------------------------------------------------
module ple_search #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [CAPACITY-1:0]         match_i,
  output logic                        hit_o,
  output logic [$clog2(CAPACITY)-1:0] idx_o
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int TREE_N = 2 ** IDX_W;

  logic [TREE_N-1:0] leaf_q;
  logic [TREE_N-1:1] node_any_q;
  logic [IDX_W-1:0]  node_idx_q [1:TREE_N-1];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      leaf_q <= TREE_N'(match_i);
    end
  end

  for (genvar n = 1; n < TREE_N; n++) begin : g_node
    localparam int L = 2 * n;
    localparam int R = 2 * n + 1;
    logic             any_l, any_r;
    logic [IDX_W-1:0] idx_l, idx_r;

    if (L >= TREE_N) begin : g_leaf
      assign any_l = leaf_q[L-TREE_N];
      assign any_r = leaf_q[R-TREE_N];
      assign idx_l = IDX_W'(L - TREE_N);
      assign idx_r = IDX_W'(R - TREE_N);
    end else begin : g_inner
      assign any_l = node_any_q[L];
      assign any_r = node_any_q[R];
      assign idx_l = node_idx_q[L];
      assign idx_r = node_idx_q[R];
    end

    always_ff @(posedge clk_i) begin
      node_any_q[n] <= any_l | any_r;
      node_idx_q[n] <= any_l ? idx_l : idx_r;
    end
  end

  assign hit_o = node_any_q[1];
  assign idx_o = node_idx_q[1];

endmodule

/* rtl/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed values kept in a row of shifting cells.
//
// Commands arrive as words on the cmd channel (command, value, position) and
// each gives exactly one word on the rsp channel (status, found position,
// count after the command). Positions count from 1 at the head.
// Push, pop, insert, delete, rewrite and clear update the list at the
// accepting edge; their response is valid in the next cycle, so one such
// command a cycle is taken while the receiver keeps up.
// Find registers the per-cell compare results and walks a registered tree,
// one level a cycle; its response is registered once the search counter
// runs out, and no command is taken meanwhile.
// The response sits in an output register; a new command is taken while it
// is being read, and held off while it waits on a stalled receiver.
// Reset empties the list (count 0); entry contents are not cleared and are
// never read before being written. Failed commands leave the list as it was.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ple_cmd_if.sink     cmd,
  ple_rsp_if.source   rsp
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
  localparam int FP_W   = (IDX_W + 1 > ple_pkg::FPOS_W) ? IDX_W + 1 : ple_pkg::FPOS_W;
  localparam int SCNT_W = $clog2(IDX_W + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_e;

  state_e                         state_q;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [SCNT_W-1:0]              scnt_q;
  logic                           rsp_valid_q, rsp_valid_d;
  logic [ple_pkg::STATUS_W-1:0]   rsp_status_q;
  logic [ple_pkg::FPOS_W-1:0]     rsp_found_q;
  logic [ple_pkg::COUNT_W-1:0]    rsp_count_q;

  logic                  accept;
  logic [DATA_WIDTH-1:0] val_ext;
  logic [CMP_W-1:0]      pos_ext, cnt_ext;
  logic [IDX_W-1:0]      pos_m1, tgt_idx;
  logic                  open_en, close_en, write_en, is_find;
  ple_pkg::status_e      status_d;
  logic                  is_full, is_empty, bad_pos;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic                  srch_hit;
  logic [IDX_W-1:0]      srch_idx;

  assign cmd.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  if (DATA_WIDTH <= ple_pkg::VALUE_W) begin : g_trunc
    assign val_ext = cmd.value[DATA_WIDTH-1:0];
  end else begin : g_sext
    assign val_ext = {{(DATA_WIDTH - ple_pkg::VALUE_W){cmd.value[ple_pkg::VALUE_W-1]}},
                      cmd.value};
  end

  assign pos_ext  = CMP_W'(cmd.position);
  assign cnt_ext  = CMP_W'(count_q);
  assign pos_m1   = IDX_W'(pos_ext - CMP_W'(1));
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign bad_pos  = (pos_ext == '0) || (pos_ext > cnt_ext);

  always_comb begin
    status_d = ple_pkg::ST_OK;
    count_d  = count_q;
    open_en  = 1'b0;
    close_en = 1'b0;
    write_en = 1'b0;
    is_find  = 1'b0;
    tgt_idx  = '0;
    unique case (ple_pkg::cmd_e'(cmd.command))
      ple_pkg::CMD_PUSH_FRONT, ple_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          open_en = 1'b1;
          tgt_idx = (ple_pkg::cmd_e'(cmd.command) == ple_pkg::CMD_PUSH_FRONT) ?
                    '0 : IDX_W'(count_q);
        end
      end
      ple_pkg::CMD_POP_FRONT, ple_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_d = ple_pkg::ST_EMPTY;
        end else begin
          close_en = 1'b1;
          tgt_idx  = (ple_pkg::cmd_e'(cmd.command) == ple_pkg::CMD_POP_FRONT) ?
                     '0 : IDX_W'(count_q - CNT_W'(1));
        end
      end
      ple_pkg::CMD_INSERT_AT: begin
        if (bad_pos) begin
          status_d = ple_pkg::ST_RANGE;
        end else if (is_full) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          open_en = 1'b1;
          tgt_idx = pos_m1;
        end
      end
      ple_pkg::CMD_DELETE_AT, ple_pkg::CMD_REWRITE_AT: begin
        if (is_empty) begin
          status_d = ple_pkg::ST_EMPTY;
        end else if (bad_pos) begin
          status_d = ple_pkg::ST_RANGE;
        end else begin
          close_en = (ple_pkg::cmd_e'(cmd.command) == ple_pkg::CMD_DELETE_AT);
          write_en = (ple_pkg::cmd_e'(cmd.command) == ple_pkg::CMD_REWRITE_AT);
          tgt_idx  = pos_m1;
        end
      end
      ple_pkg::CMD_FIND: begin
        is_find = 1'b1;
      end
      ple_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    if (open_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (close_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    ple_pkg::cell_ctl_t    ctl;
    logic [DATA_WIDTH-1:0] left, right;
    logic                  hit;

    assign ctl.take_new   = accept && (open_en || write_en) && (IDX_W'(j) == tgt_idx);
    assign ctl.take_left  = accept && open_en && (IDX_W'(j) > tgt_idx);
    assign ctl.take_right = accept && close_en && (IDX_W'(j) >= tgt_idx);

    if (j == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[j-1];
    end
    if (j == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[j+1];
    end

    ple_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .value_i (val_ext),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[j]),
      .hit_o   (hit)
    );

    assign match[j] = hit && (CNT_W'(j) < count_q);
  end

  ple_search #(
    .CAPACITY (CAPACITY)
  ) u_search (
    .clk_i   (clk_i),
    .load_i  (accept && is_find),
    .match_i (match),
    .hit_o   (srch_hit),
    .idx_o   (srch_idx)
  );

  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp.ready;
    if ((accept && !is_find) || ((state_q == S_SEARCH) && (scnt_q == '0))) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scnt_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q <= count_d;
            if (is_find) begin
              state_q <= S_SEARCH;
              scnt_q  <= SCNT_W'(IDX_W);
            end
          end
        end
        S_SEARCH: begin
          if (scnt_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            scnt_q <= scnt_q - SCNT_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_find) begin
      rsp_status_q <= status_d;
      rsp_found_q  <= '0;
      rsp_count_q  <= ple_pkg::COUNT_W'(count_d);
    end else if ((state_q == S_SEARCH) && (scnt_q == '0)) begin
      rsp_status_q <= srch_hit ? ple_pkg::ST_OK : ple_pkg::ST_NOTFOUND;
      rsp_found_q  <= srch_hit ? ple_pkg::FPOS_W'(FP_W'(srch_idx) + FP_W'(1)) : '0;
      rsp_count_q  <= ple_pkg::COUNT_W'(count_q);
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.status         = rsp_status_q;
  assign rsp.found_position = rsp_found_q;
  assign rsp.count          = rsp_count_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the positional list engine word by word: a directed table covers
// the empty, range, full-free edge cases and the value extremes, then random
// rounds fill the list to capacity, drain it past empty and mix all commands.
// Every response is compared field by field with the table's word or with a
// behavioral list model in the testbench, under sender bursts and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import ple_pkg::*;

  localparam int          CAPACITY     = 64;
  localparam int          DATA_W       = 32;
  localparam int          RAND_ITEMS   = 850;
  localparam int          LONG_HOLD    = 80;
  localparam int          SETTLE       = 20;
  localparam logic [3:0]  CMD_SPARE_LO = 4'd9;
  localparam logic [3:0]  CMD_SPARE_HI = 4'd15;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} round_mode_e;

  typedef struct packed {
    status_e            status;
    logic [FPOS_W-1:0]  found_position;
    logic [COUNT_W-1:0] count;
  } rsp_word_t;

  typedef struct {
    logic [CMD_W-1:0]   op;
    logic [DATA_W-1:0]  val;
    logic [POS_W-1:0]   pos;
    bit                 typed;
    rsp_word_t          rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  ple_cmd_if cmd_bus ();
  ple_rsp_if rsp_bus ();

  positional_list_engine #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_W)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd    (cmd_bus),
    .rsp    (rsp_bus)
  );

  logic [DATA_W-1:0] list_mem [CAPACITY];
  int unsigned       list_len;
  int unsigned       list_peak;
  rsp_word_t         pending_rsp [$];
  dir_row_t          dir_rows [$];
  int unsigned       fail_cnt;
  int unsigned       words_checked;
  int unsigned       status_seen [8];
  int unsigned       burst_left;
  bit                burst_quiet;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // ---- list model ----------------------------------------------------------
  task automatic list_open(input int unsigned idx, input logic [DATA_W-1:0] val);
    int unsigned i;
    for (i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
    list_mem[idx] = val;
    list_len++;
    if (list_len > list_peak) list_peak = list_len;
  endtask

  task automatic list_close(input int unsigned idx);
    int unsigned i;
    for (i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endtask

  task automatic list_apply(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                            input logic [POS_W-1:0] pos, output rsp_word_t res);
    int unsigned i;
    res.status         = ST_OK;
    res.found_position = '0;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (list_len >= CAPACITY) res.status = ST_FULL;
        else list_open((op == CMD_PUSH_FRONT) ? 0 : list_len, val);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_close((op == CMD_POP_FRONT) ? 0 : list_len - 1);
      end
      CMD_INSERT_AT: begin
        if (pos < 1 || pos > list_len) res.status = ST_RANGE;
        else if (list_len >= CAPACITY) res.status = ST_FULL;
        else list_open(pos - 1, val);
      end
      CMD_DELETE_AT, CMD_REWRITE_AT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (pos < 1 || pos > list_len) res.status = ST_RANGE;
        else if (op == CMD_DELETE_AT) list_close(pos - 1);
        else list_mem[pos-1] = val;
      end
      CMD_FIND: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (res.status == ST_NOTFOUND && list_mem[i] == val) begin
            res.status         = ST_OK;
            res.found_position = FPOS_W'(i + 1);
          end
        end
      end
      CMD_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = COUNT_W'(list_len);
  endtask

  // ---- command side --------------------------------------------------------
  task automatic send_word(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos, input bit typed,
                           input rsp_word_t typed_rsp);
    rsp_word_t want;
    if (burst_left == 0) begin
      burst_left  = $urandom_range(1, 30);
      burst_quiet = ($urandom_range(0, 3) == 0);
      if (!burst_quiet) begin
        cmd_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_bus.valid    <= 1'b1;
    cmd_bus.command  <= op;
    cmd_bus.value    <= val;
    cmd_bus.position <= pos;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    list_apply(op, val, pos, want);
    if (typed) want = typed_rsp;
    pending_rsp.push_back(want);
  endtask

  task automatic drain_wait();
    cmd_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                         input int pos, input bit typed,
                         input status_e st, input int fpos, input int cnt);
    dir_row_t row;
    row.op                 = op;
    row.val                = val;
    row.pos                = POS_W'(pos);
    row.typed              = typed;
    row.rsp.status         = st;
    row.rsp.found_position = FPOS_W'(fpos);
    row.rsp.count          = COUNT_W'(cnt);
    dir_rows.push_back(row);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35 && list_len != 0) return list_mem[$urandom_range(0, list_len - 1)];
    if (r < 55) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return '1;
        2: return {1'b1, {(DATA_W-1){1'b0}}};
        3: return {1'b0, {(DATA_W-1){1'b1}}};
        default: return DATA_W'(1);
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65 && list_len != 0) return POS_W'($urandom_range(1, list_len));
    if (r < 75) return '0;
    if (r < 85) return POS_W'(list_len + 1);
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CMD_W-1:0] any_op();
    if ($urandom_range(0, 19) == 0)
      return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    return CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_CLEAR));
  endfunction

  task automatic random_round(input round_mode_e mode, input int n_items,
                              inout int unsigned sent);
    int               k;
    int unsigned      r;
    logic [CMD_W-1:0] op;
    logic [DATA_W-1:0] val;
    rsp_word_t        none;
    none = '0;
    for (k = 0; k < n_items; k++) begin
      r  = $urandom_range(0, 99);
      op = any_op();
      if (mode == MODE_GROW && r < 85) begin
        case ($urandom_range(0, 2))
          0:       op = CMD_PUSH_FRONT;
          1:       op = CMD_PUSH_BACK;
          default: op = CMD_INSERT_AT;
        endcase
      end else if (mode == MODE_SHRINK && r < 80) begin
        case ($urandom_range(0, 2))
          0:       op = CMD_POP_FRONT;
          1:       op = CMD_POP_BACK;
          default: op = CMD_DELETE_AT;
        endcase
      end
      val = pick_value();
      if (op == CMD_FIND && list_len != 0 && $urandom_range(0, 9) < 6)
        val = list_mem[$urandom_range(0, list_len - 1)];
      send_word(op, val, pick_pos(), 1'b0, none);
      sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    rsp_word_t   none;
    none          = '0;
    sent          = 0;
    list_len      = 0;
    list_peak     = 0;
    burst_left    = 0;
    fail_cnt      = 0;
    words_checked = 0;
    rst_ni        = 1'b0;
    cmd_bus.valid    <= 1'b0;
    cmd_bus.command  <= CMD_CLEAR;
    cmd_bus.value    <= '0;
    cmd_bus.position <= '0;

    add_row(CMD_POP_FRONT,  '0,           0,   1, ST_EMPTY,    0, 0);
    add_row(CMD_POP_BACK,   '0,           0,   1, ST_EMPTY,    0, 0);
    add_row(CMD_DELETE_AT,  '0,           1,   1, ST_EMPTY,    0, 0);
    add_row(CMD_REWRITE_AT, '0,           0,   1, ST_EMPTY,    0, 0);
    add_row(CMD_INSERT_AT,  32'h1,        1,   1, ST_RANGE,    0, 0);
    add_row(CMD_FIND,       '0,           0,   1, ST_NOTFOUND, 0, 0);
    add_row(CMD_PUSH_FRONT, 32'h7fffffff, 0,   1, ST_OK,       0, 1);
    add_row(CMD_PUSH_BACK,  32'h80000000, 255, 1, ST_OK,       0, 2);
    add_row(CMD_FIND,       32'h80000000, 0,   1, ST_OK,       2, 2);
    add_row(CMD_INSERT_AT,  32'h5,        0,   1, ST_RANGE,    0, 2);
    add_row(CMD_INSERT_AT,  32'h5,        3,   1, ST_RANGE,    0, 2);
    add_row(CMD_INSERT_AT,  32'hffffffff, 1,   1, ST_OK,       0, 3);
    add_row(CMD_DELETE_AT,  '0,           255, 1, ST_RANGE,    0, 3);
    add_row(CMD_REWRITE_AT, 32'h3,        0,   1, ST_RANGE,    0, 3);
    add_row(CMD_REWRITE_AT, 32'h0,        3,   1, ST_OK,       0, 3);
    add_row(CMD_FIND,       32'h0,        0,   1, ST_OK,       3, 3);
    add_row(CMD_INSERT_AT,  32'h1,        3,   0, ST_OK,       0, 0);
    add_row(CMD_PUSH_BACK,  32'h1,        0,   0, ST_OK,       0, 0);
    add_row(CMD_FIND,       32'h1,        0,   0, ST_OK,       0, 0);
    add_row(CMD_DELETE_AT,  '0,           2,   0, ST_OK,       0, 0);
    add_row(CMD_SPARE_LO,   32'hffffffff, 255, 1, ST_OK,       0, 4);
    add_row(CMD_SPARE_HI,   32'h0,        0,   1, ST_OK,       0, 4);
    add_row(CMD_POP_FRONT,  '0,           0,   0, ST_OK,       0, 0);
    add_row(CMD_POP_BACK,   '0,           0,   0, ST_OK,       0, 0);
    add_row(CMD_CLEAR,      '0,           0,   1, ST_OK,       0, 0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].val, dir_rows[i].pos, dir_rows[i].typed,
                dir_rows[i].rsp);

    // fill past capacity, then drain past empty
    random_round(MODE_GROW, 120, sent);
    random_round(MODE_SHRINK, 110, sent);
    drain_wait();
    while (sent < RAND_ITEMS) begin
      n = $urandom_range(40, 120);
      if (n > RAND_ITEMS - sent) n = RAND_ITEMS - sent;
      random_round(round_mode_e'($urandom_range(MODE_GROW, MODE_MIXED)), n, sent);
    end

    cmd_bus.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d response words checked, list depth peaked at %0d of %0d",
             words_checked, list_peak, CAPACITY);
    $display("status mix: ok %0d, empty %0d, range %0d, full %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
             status_seen[ST_FULL], status_seen[ST_NOTFOUND]);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---- response side -------------------------------------------------------
  initial begin : rsp_stall
    int  mode;
    int  span;
    int  k;
    bit  held;
    held = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && words_checked >= 300) begin
        // hold off long enough for the command side to back up
        held = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (k = 0; k < span; k++) begin
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          2:       rsp_bus.ready <= k[0];
          default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    rsp_word_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response word with no command outstanding");
        fail_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        words_checked++;
        status_seen[want.status]++;
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          fail_cnt++;
        end
        if (rsp_bus.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d", want.found_position,
                 rsp_bus.found_position);
          fail_cnt++;
        end
        if (rsp_bus.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_bus.count);
          fail_cnt++;
        end
      end
    end
  end

endmodule
